// File: hdl/control_error_protection_monitor_defines.svh
// assertion macros for the control error protection monitor
// no dependencies; included by the monitor module, which carries assertions
`ifndef CONTROL_ERROR_PROTECTION_MONITOR_DEFINES_SVH
`define CONTROL_ERROR_PROTECTION_MONITOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CEPM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cepm assertion failed");

// next-cycle implication, disabled during reset
`define CEPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cepm assertion failed");

`endif

// File: hdl/cepm_pkg.sv
// shared types and constants of the control error protection monitor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cepm_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   localparam int LIMIT_WIDTH     = 16;
   localparam int TOL_WIDTH       = 31;
   localparam int CSR_DATA_WIDTH  = 31;
   localparam int CSR_INDEX_WIDTH = 2;

   // 100 percent scaled by one in Q16.16
   localparam int PCT_SCALE_WIDTH = 23;
   localparam logic [PCT_SCALE_WIDTH-1:0] PCT_SCALE = 23'd6553600;
   localparam int ONE_Q16 = 65536;

   localparam logic [LIMIT_WIDTH-1:0] GROWTH_LIMIT_RESET     = 16'd10;
   localparam logic [LIMIT_WIDTH-1:0] STAGNATION_LIMIT_RESET = 16'd10;
   localparam logic [TOL_WIDTH-1:0]   PERCENT_TOL_RESET      = 31'd327680;
   localparam logic [TOL_WIDTH-1:0]   ABSOLUTE_TOL_RESET     = 31'd32768;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_GROWTH_LIMIT     = 2'd0,
      REG_STAGNATION_LIMIT = 2'd1,
      REG_PERCENT_TOL      = 2'd2,
      REG_ABSOLUTE_TOL     = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      MODE_INIT    = 2'd0,
      MODE_MONITOR = 2'd1,
      MODE_FAULT   = 2'd2,
      MODE_RESET   = 2'd3
   } mode_type;

endpackage

`default_nettype wire

// File: hdl/control_error_protection_monitor.sv
// control error protection monitor: growth and tolerance run counters, fault mode
// depends on cepm_pkg and control_error_protection_monitor_defines.svh
//
//   channel  ports                                  direction
//   req      req_valid, req_stall, req_cmd, samples  in (one sample word)
//   rsp      rsp_valid, rsp_stall, status fields     out (one status word)
//   csr      csr_wen, csr_index, csr_wdata           in (write only)
//
// one word per cycle sustained while the result is not stalled; a result is registered
// after acceptance (input register, then the update logic into the result register)
// the tolerance compare uses one constant multiply and one 31 x ADJ_WIDTH multiply
// synchronous reset clears state, restores the register defaults, empties both stages
// a stalled result holds; the input register still takes one word behind it
`timescale 1ns / 1ps
`default_nettype none

`include "control_error_protection_monitor_defines.svh"

module control_error_protection_monitor #(
   parameter int COUNT_WIDTH = cepm_pkg::COUNT_WIDTH_DEFAULT,
   parameter int VALUE_WIDTH = cepm_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,

   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic                                   req_cmd,
   input  wire logic signed [VALUE_WIDTH-1:0]          req_control_error,
   input  wire logic signed [VALUE_WIDTH-1:0]          req_target_level,
   input  wire logic signed [VALUE_WIDTH-1:0]          req_measured_level,

   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic                                        rsp_fault,
   output logic                                        rsp_growth_event,
   output logic                                        rsp_stagnation_event,
   output logic [1:0]                                  rsp_mode_now,

   input  wire logic                                   csr_wen,
   input  wire logic [cepm_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [cepm_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   localparam int ERR_WIDTH  = VALUE_WIDTH + 1;
   localparam int ADJ_WIDTH  = (VALUE_WIDTH > 17) ? VALUE_WIDTH - 1 : 17;
   localparam int ABS_CMP_W  = (ERR_WIDTH > cepm_pkg::TOL_WIDTH) ? ERR_WIDTH
                                                                 : cepm_pkg::TOL_WIDTH;
   localparam int LHS_W      = ERR_WIDTH + cepm_pkg::PCT_SCALE_WIDTH;
   localparam int RHS_W      = cepm_pkg::TOL_WIDTH + ADJ_WIDTH;
   localparam int PROD_W     = (LHS_W > RHS_W) ? LHS_W : RHS_W;
   localparam int CNT_CMP_W  = (COUNT_WIDTH > cepm_pkg::LIMIT_WIDTH) ? COUNT_WIDTH
                                                                     : cepm_pkg::LIMIT_WIDTH;

   // configuration registers
   logic [cepm_pkg::LIMIT_WIDTH-1:0] growth_limit_ff;
   logic [cepm_pkg::LIMIT_WIDTH-1:0] stagnation_limit_ff;
   logic [cepm_pkg::TOL_WIDTH-1:0]   percent_tol_ff;
   logic [cepm_pkg::TOL_WIDTH-1:0]   absolute_tol_ff;

   // input stage
   logic                            in_valid_ff, in_valid_in;
   logic                            in_cmd_ff;
   logic signed [VALUE_WIDTH-1:0]   in_ce_ff;
   logic signed [VALUE_WIDTH-1:0]   in_sp_ff;
   logic signed [VALUE_WIDTH-1:0]   in_out_ff;

   // monitor state
   cepm_pkg::mode_type              mode_ff, mode_in;
   logic signed [VALUE_WIDTH-1:0]   prev_error_ff, prev_error_in;
   logic [COUNT_WIDTH-1:0]          growth_count_ff, growth_count_in;
   logic [COUNT_WIDTH-1:0]          stagnation_count_ff, stagnation_count_in;
   logic [1:0]                      event_flags_ff, event_flags_in;
   logic                            fault_in;

   // result stage
   logic                            rsp_valid_ff;
   logic                            rsp_fault_ff;
   logic [1:0]                      rsp_flags_ff;
   cepm_pkg::mode_type              rsp_mode_ff;

   logic                            advance;

   // datapath
   logic signed [ERR_WIDTH-1:0]     diff;
   logic [ERR_WIDTH-1:0]            err;
   logic                            over_abs;
   logic                            sp_small;
   logic [ADJ_WIDTH-1:0]            adj;
   logic [PROD_W-1:0]               lhs;
   logic [PROD_W-1:0]               rhs;
   logic                            over_rel;
   logic                            rising;
   logic [COUNT_WIDTH-1:0]          growth_inc;
   logic [COUNT_WIDTH-1:0]          stagnation_inc;

   assign advance     = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign in_valid_in = (req_valid && !req_stall) || (in_valid_ff && !advance);

   assign diff     = ERR_WIDTH'(in_sp_ff) - ERR_WIDTH'(in_out_ff);
   assign err      = diff[ERR_WIDTH-1] ? ERR_WIDTH'(-diff) : ERR_WIDTH'(diff);
   assign over_abs = ABS_CMP_W'(err) > ABS_CMP_W'(absolute_tol_ff);

   // adjusted setpoint: max(setpoint, 1.0)
   assign sp_small = in_sp_ff[VALUE_WIDTH-1] ||
                     (ADJ_WIDTH'(in_sp_ff[VALUE_WIDTH-2:0]) < ADJ_WIDTH'(cepm_pkg::ONE_Q16));
   assign adj      = sp_small ? ADJ_WIDTH'(cepm_pkg::ONE_Q16)
                              : ADJ_WIDTH'(in_sp_ff[VALUE_WIDTH-2:0]);

   assign lhs      = PROD_W'(err) * PROD_W'(cepm_pkg::PCT_SCALE);
   assign rhs      = PROD_W'(percent_tol_ff) * PROD_W'(adj);
   assign over_rel = lhs > rhs;

   assign rising   = in_ce_ff > prev_error_ff;

   assign growth_inc     = (growth_count_ff == '1) ? growth_count_ff
                                                   : growth_count_ff + COUNT_WIDTH'(1);
   assign stagnation_inc = (stagnation_count_ff == '1) ? stagnation_count_ff
                                                       : stagnation_count_ff + COUNT_WIDTH'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         growth_limit_ff     <= cepm_pkg::GROWTH_LIMIT_RESET;
         stagnation_limit_ff <= cepm_pkg::STAGNATION_LIMIT_RESET;
         percent_tol_ff      <= cepm_pkg::PERCENT_TOL_RESET;
         absolute_tol_ff     <= cepm_pkg::ABSOLUTE_TOL_RESET;
      end else if (csr_wen) begin
         unique case (cepm_pkg::reg_index_type'(csr_index))
            cepm_pkg::REG_GROWTH_LIMIT:
               growth_limit_ff <= csr_wdata[cepm_pkg::LIMIT_WIDTH-1:0];
            cepm_pkg::REG_STAGNATION_LIMIT:
               stagnation_limit_ff <= csr_wdata[cepm_pkg::LIMIT_WIDTH-1:0];
            cepm_pkg::REG_PERCENT_TOL:
               percent_tol_ff <= csr_wdata[cepm_pkg::TOL_WIDTH-1:0];
            cepm_pkg::REG_ABSOLUTE_TOL:
               absolute_tol_ff <= csr_wdata[cepm_pkg::TOL_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid && !req_stall) begin
         in_cmd_ff <= req_cmd;
         in_ce_ff  <= req_control_error;
         in_sp_ff  <= req_target_level;
         in_out_ff <= req_measured_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff             <= cepm_pkg::MODE_INIT;
         prev_error_ff       <= '0;
         growth_count_ff     <= '0;
         stagnation_count_ff <= '0;
         event_flags_ff      <= '0;
      end else if (advance) begin
         mode_ff             <= mode_in;
         prev_error_ff       <= prev_error_in;
         growth_count_ff     <= growth_count_in;
         stagnation_count_ff <= stagnation_count_in;
         event_flags_ff      <= event_flags_in;
      end
   end

   always_comb begin
      mode_in             = mode_ff;
      prev_error_in       = prev_error_ff;
      growth_count_in     = growth_count_ff;
      stagnation_count_in = stagnation_count_ff;
      event_flags_in      = event_flags_ff;
      fault_in            = 1'b0;
      if (in_cmd_ff) begin
         mode_in             = cepm_pkg::MODE_RESET;
         prev_error_in       = '0;
         growth_count_in     = '0;
         stagnation_count_in = '0;
      end else begin
         unique case (mode_ff)
            cepm_pkg::MODE_INIT: begin
               mode_in             = cepm_pkg::MODE_MONITOR;
               prev_error_in       = '0;
               growth_count_in     = '0;
               stagnation_count_in = '0;
            end
            cepm_pkg::MODE_MONITOR: begin
               prev_error_in   = in_ce_ff;
               growth_count_in = rising ? growth_inc : '0;
               if (over_abs) begin
                  stagnation_count_in = over_rel ? stagnation_inc : '0;
               end else begin
                  stagnation_count_in = '0;
                  growth_count_in     = '0;
               end
               // growth is checked first
               if (CNT_CMP_W'(growth_count_in) >= CNT_CMP_W'(growth_limit_ff)) begin
                  event_flags_in[0] = 1'b1;
                  fault_in          = 1'b1;
                  mode_in           = cepm_pkg::MODE_FAULT;
               end else if (CNT_CMP_W'(stagnation_count_in) >=
                            CNT_CMP_W'(stagnation_limit_ff)) begin
                  event_flags_in[1] = 1'b1;
                  fault_in          = 1'b1;
                  mode_in           = cepm_pkg::MODE_FAULT;
               end
            end
            cepm_pkg::MODE_FAULT: begin
               fault_in = 1'b1;
            end
            cepm_pkg::MODE_RESET: begin
               mode_in = cepm_pkg::MODE_INIT;
            end
            default: begin
               mode_in = cepm_pkg::MODE_INIT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_fault_ff <= fault_in;
         rsp_flags_ff <= event_flags_in;
         rsp_mode_ff  <= mode_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_fault            = rsp_fault_ff;
   assign rsp_growth_event     = rsp_flags_ff[0];
   assign rsp_stagnation_event = rsp_flags_ff[1];
   assign rsp_mode_now         = rsp_mode_ff;

   // fault is reported exactly when the word leaves in fault mode
   `CEPM_ASSERT_SAME(a_fault_mode, clock, reset, rsp_valid_ff,
      rsp_fault_ff == (rsp_mode_ff == cepm_pkg::MODE_FAULT))

   // event bits are sticky
   `CEPM_ASSERT_NEXT(a_growth_sticky, clock, reset, event_flags_ff[0], event_flags_ff[0])
   `CEPM_ASSERT_NEXT(a_stag_sticky, clock, reset, event_flags_ff[1], event_flags_ff[1])

   // run counts only live in monitor or fault mode
   `CEPM_ASSERT_SAME(a_count_mode, clock, reset,
      (growth_count_ff != '0) || (stagnation_count_ff != '0),
      (mode_ff == cepm_pkg::MODE_MONITOR) || (mode_ff == cepm_pkg::MODE_FAULT))

   // a word leaving the input register shows up as a result
   `CEPM_ASSERT_NEXT(a_advance_rsp, clock, reset, advance, rsp_valid_ff)

endmodule

`default_nettype wire
